### rtl/core/lpp_pkg.sv
package lpp_pkg;

    localparam int SampleW = 16;
    localparam int ValW    = 20;
    localparam int IdxW    = 10;
    localparam int SumW    = 64;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 11;

    localparam logic [CfgIdxW-1:0] RegPNorm       = 3'd0;
    localparam logic [CfgIdxW-1:0] RegPoolWidth   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegPoolHeight  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegPlaneWidth  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegPlaneHeight = 3'd4;

    typedef struct packed {
        logic [ValW-1:0] pooled_value;
        logic [IdxW-1:0] out_col;
        logic [IdxW-1:0] out_row;
        logic            last_of_plane;
    } t_result;

endpackage

### rtl/core/lp_norm_pooling.sv
// A sample is accepted in S_IDLE and raised to the p-th power in S_POW; multiplies run as two
// 32x32 halves. S_RD reads the partial sum, and S_UPD accumulates it inside the pooled area.
// A window-closing sample then raises m_axis_tvalid after S_RSET and, for p>1, a 32-bit root:
// per bit, S_RMUL raises the candidate to the p-th power and S_RCHK keeps or drops the bit.
// Throughput: one sample at a time; a waiting result stalls only the next finished result.
// Reset (synchronous, active low) restores register defaults and clears counters.
module lp_norm_pooling #(
    parameter int MAX_PLANE_WIDTH  = 1024,
    parameter int MAX_PLANE_HEIGHT = 1024,
    parameter int MAX_POOL         = 4,
    parameter int MAX_P            = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [19:0] pooled_value, [29:20] out_col, [39:30] out_row
    output logic        m_axis_tlast,   // last_of_plane
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_PLANE_WIDTH + 1);
    localparam int RW = $clog2(MAX_PLANE_HEIGHT + 1);
    localparam int AW = $clog2(MAX_PLANE_WIDTH);
    localparam int PW = $clog2(MAX_POOL + 1);
    localparam int SW = lpp_pkg::SumW;

    localparam logic [3:0] S_IDLE = 4'd0, S_POW = 4'd1, S_RD = 4'd2, S_UPD = 4'd3,
                           S_RSET = 4'd4, S_RMUL = 4'd5, S_RCHK = 4'd6, S_OUT = 4'd7;

    logic [2:0]  r_p_norm, r_pool_w, r_pool_h;
    logic [10:0] r_plane_w, r_plane_h;
    logic [3:0]  r_state;
    logic        cfg_we;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_norm <= 3'd2; r_pool_w <= 3'd2; r_pool_h <= 3'd2;
            r_plane_w <= 11'd64; r_plane_h <= 11'd64;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                lpp_pkg::RegPNorm:       r_p_norm  <= i_cfg_data[2:0];
                lpp_pkg::RegPoolWidth:   r_pool_w  <= i_cfg_data[2:0];
                lpp_pkg::RegPoolHeight:  r_pool_h  <= i_cfg_data[2:0];
                lpp_pkg::RegPlaneWidth:  r_plane_w <= i_cfg_data;
                lpp_pkg::RegPlaneHeight: r_plane_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped configuration
    logic [2:0]  p_c;
    logic [PW-1:0] pw_c, ph_c;
    logic [CW-1:0] w_c;
    logic [RW-1:0] h_c;
    always_comb begin
        p_c = (r_p_norm == 3'd0) ? 3'd1 :
              (32'(r_p_norm) > MAX_P) ? 3'(MAX_P) : r_p_norm;
        pw_c = (r_pool_w == 3'd0) ? PW'(1) :
               (32'(r_pool_w) > MAX_POOL) ? PW'(MAX_POOL) : PW'(r_pool_w);
        ph_c = (r_pool_h == 3'd0) ? PW'(1) :
               (32'(r_pool_h) > MAX_POOL) ? PW'(MAX_POOL) : PW'(r_pool_h);
        w_c = (r_plane_w == 11'd0) ? CW'(1) :
              (32'(r_plane_w) > MAX_PLANE_WIDTH) ? CW'(MAX_PLANE_WIDTH) : CW'(r_plane_w);
        h_c = (r_plane_h == 11'd0) ? RW'(1) :
              (32'(r_plane_h) > MAX_PLANE_HEIGHT) ? RW'(MAX_PLANE_HEIGHT) : RW'(r_plane_h);
    end

    logic [CW-1:0] r_in_col, r_oc;
    logic [RW-1:0] r_in_row, r_orow, r_row_nb;
    logic [PW-1:0] r_cph, r_rph;
    logic [CW-1:0] col_lim;   // ow*pw
    logic [RW-1:0] row_lim;   // oh*ph
    logic [CW-1:0] ow;
    logic [RW-1:0] oh;
    // w/pw, h/ph and in_row/ph by repeated addition after reset or a config write
    logic [CW-1:0] r_ow, r_owacc;
    logic [RW-1:0] r_oh, r_ohacc;
    logic [CW-1:0] r_dw_cnt;
    logic [RW-1:0] r_dh_cnt, r_dq_cnt;
    logic          r_div_done;
    assign ow = r_ow; assign oh = r_oh;
    assign col_lim = CW'(32'(r_ow) * 32'(pw_c));
    assign row_lim = RW'(32'(r_oh) * 32'(ph_c));

    logic [15:0] r_mag;
    logic [SW-1:0] r_term, r_sum, r_pw, r_plo;
    logic [31:0] r_root, r_cand;
    logic        r_ov, r_mph;
    logic [2:0]  r_k;
    logic [5:0]  r_bit;
    logic        r_win_start, r_win_end, r_active;
    logic [AW-1:0] r_addr;
    logic [SW-1:0] mem [MAX_PLANE_WIDTH];
    logic [SW-1:0] r_rd;
    logic        r_out_v;
    lpp_pkg::t_result r_res;
    logic [lpp_pkg::ValW-1:0] r_val;
    logic [lpp_pkg::IdxW-1:0] r_wcol, r_wrow;
    logic        r_wlast;
    logic        acc_in, row_adv, out_load;
    logic [31:0] mul_a, mul_b;
    logic [2*32-1:0] prod;
    logic [SW:0] mul_sum;
    logic [SW:0] add_full;
    logic [SW-1:0] n_sum;
    logic [31:0] nr;

    assign s_axis_tready = (r_state == S_IDLE) && r_div_done && !i_cfg_valid;
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign row_adv = acc_in && (r_in_col + 1'b1 >= w_c);
    assign out_load = (r_state == S_OUT) && (!r_out_v || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_div_done <= 1'b0;
            r_dw_cnt <= '0; r_dh_cnt <= '0; r_dq_cnt <= '0;
            r_owacc <= '0; r_ohacc <= '0;
            r_ow <= '0; r_oh <= '0;
            r_orow <= '0; r_row_nb <= '0;
        end else if (!r_div_done) begin
            if (r_dw_cnt + CW'(pw_c) <= w_c) begin
                r_dw_cnt <= r_dw_cnt + CW'(pw_c); r_owacc <= r_owacc + 1'b1;
            end
            if (r_dh_cnt + RW'(ph_c) <= h_c) begin
                r_dh_cnt <= r_dh_cnt + RW'(ph_c); r_ohacc <= r_ohacc + 1'b1;
            end
            if (r_dq_cnt + RW'(ph_c) <= r_in_row) begin
                r_dq_cnt <= r_dq_cnt + RW'(ph_c); r_orow <= r_orow + 1'b1;
            end
            if (!(r_dw_cnt + CW'(pw_c) <= w_c) && !(r_dh_cnt + RW'(ph_c) <= h_c) &&
                !(r_dq_cnt + RW'(ph_c) <= r_in_row)) begin
                r_div_done <= 1'b1; r_ow <= r_owacc; r_oh <= r_ohacc;
                r_row_nb <= r_dq_cnt + RW'(ph_c);
            end
        end else if (row_adv) begin
            // r_row_nb is the first row of the next output row
            if (r_in_row + 1'b1 >= h_c) begin
                r_orow <= '0; r_row_nb <= RW'(ph_c);
            end else if (r_in_row + 1'b1 >= r_row_nb) begin
                r_orow <= r_orow + 1'b1; r_row_nb <= r_row_nb + RW'(ph_c);
            end
        end
    end

    // shared 32x32 multiplier: low half of r_pw, then high half
    assign mul_a = r_mph ? r_pw[63:32] : r_pw[31:0];
    assign mul_b = (r_state == S_POW) ? 32'(r_mag) : r_cand;
    assign prod = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_sum = {1'b0, r_plo} + {1'b0, prod[31:0], 32'd0};

    assign add_full = {1'b0, r_rd} + {1'b0, r_term};
    assign n_sum = r_win_start ? r_term : (add_full[SW] ? {SW{1'b1}} : add_full[SW-1:0]);
    assign nr = (!r_ov && r_pw <= r_sum) ? r_cand : r_root;

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) mem[r_addr] <= n_sum;
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_in_col <= '0; r_in_row <= '0; r_cph <= '0; r_rph <= '0; r_oc <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (acc_in) begin
                    r_mag <= s_axis_tdata[15] ? 16'(17'h10000 - 17'(s_axis_tdata))
                                              : s_axis_tdata;
                    r_active <= (r_in_col < col_lim) && (r_in_row < row_lim);
                    r_win_start <= (r_cph == '0) && (r_rph == '0);
                    r_win_end <= (r_cph == pw_c - 1'b1) && (r_rph == ph_c - 1'b1);
                    r_addr <= AW'(r_oc);
                    r_pw <= 64'd1; r_ov <= 1'b0; r_k <= '0; r_mph <= 1'b0;
                    // advance counters
                    if ((r_in_col < col_lim) && (r_in_row < row_lim)) begin
                        if (r_cph + 1'b1 >= pw_c) begin
                            r_cph <= '0; r_oc <= r_oc + 1'b1;
                        end else r_cph <= r_cph + 1'b1;
                    end
                    if (r_in_col + 1'b1 >= w_c) begin
                        r_in_col <= '0; r_cph <= '0; r_oc <= '0;
                        if (r_in_row < row_lim) begin
                            if (r_rph + 1'b1 >= ph_c) r_rph <= '0;
                            else r_rph <= r_rph + 1'b1;
                        end
                        if (r_in_row + 1'b1 >= h_c) begin
                            r_in_row <= '0; r_rph <= '0;
                        end else r_in_row <= r_in_row + 1'b1;
                    end else r_in_col <= r_in_col + 1'b1;
                    r_wrow <= 10'(r_orow);
                    r_wcol <= 10'(r_oc);
                    r_wlast <= (r_oc + 1'b1 == ow) && (r_orow + 1'b1 == oh);
                    r_state <= S_POW;
                end
                S_POW: begin
                    if (r_k == p_c) begin
                        r_term <= r_pw; r_state <= S_RD;
                    end else if (!r_mph) begin
                        r_plo <= prod; r_mph <= 1'b1;
                    end else begin
                        r_pw <= mul_sum[SW-1:0]; r_k <= r_k + 1'b1; r_mph <= 1'b0;
                    end
                end
                S_RD: r_state <= r_active ? S_UPD : S_IDLE;
                S_UPD: begin
                    r_sum <= n_sum;
                    r_state <= r_win_end ? S_RSET : S_IDLE;
                end
                S_RSET: begin
                    if (p_c == 3'd1) begin
                        r_val <= (r_sum > 64'hFFFFF) ? 20'hFFFFF : r_sum[19:0];
                        r_state <= S_OUT;
                    end else begin
                        r_root <= '0; r_bit <= 6'd31;
                        r_cand <= 32'h8000_0000; r_pw <= 64'd1; r_k <= '0;
                        r_ov <= 1'b0; r_mph <= 1'b0;
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    if (r_k == p_c) r_state <= S_RCHK;
                    else if (!r_mph) begin
                        r_plo <= prod; r_mph <= 1'b1;
                    end else begin
                        if (prod[63:32] != '0 || mul_sum[SW]) r_ov <= 1'b1;
                        r_pw <= mul_sum[SW-1:0]; r_k <= r_k + 1'b1; r_mph <= 1'b0;
                    end
                end
                S_RCHK: begin
                    r_root <= nr;
                    if (r_bit == 6'd0) begin
                        r_val <= (nr > 32'hFFFFF) ? 20'hFFFFF : nr[19:0];
                        r_state <= S_OUT;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                        r_cand <= nr | (32'd1 << (r_bit - 1'b1));
                        r_pw <= 64'd1; r_k <= '0; r_ov <= 1'b0; r_mph <= 1'b0;
                        r_state <= S_RMUL;
                    end
                end
                S_OUT: if (out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register, refilled once the previous result has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else r_out_v <= out_load || (r_out_v && !m_axis_tready);
    end
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res.pooled_value  <= r_val;
            r_res.out_col       <= r_wcol;
            r_res.out_row       <= r_wrow;
            r_res.last_of_plane <= r_wlast;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {r_res.out_row, r_res.out_col, r_res.pooled_value};
    assign m_axis_tlast = r_res.last_of_plane;

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RMUL |-> r_bit <= 6'd31) else $error("root bit range");
`endif
endmodule
